// ===== hw/rtl/voxel_grid_trilinear_sampler_assert.svh =====
// Assertion macros for the RTL of the voxel grid sampler.
// Needs a clock named clk and an active-low reset named rst_n in the using scope.
`ifndef VOXEL_GRID_TRILINEAR_SAMPLER_ASSERT_SVH
`define VOXEL_GRID_TRILINEAR_SAMPLER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Checks a property at every rising clock edge outside reset.
`define VGTS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("vgts assertion failed");
// Checks that a condition never holds outside reset.
`define VGTS_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("vgts forbidden condition seen");
`else
`define VGTS_ASSERT(lbl, prop)
`define VGTS_NEVER(lbl, cond)
`endif

`endif

// ===== hw/rtl/vgts_pkg.sv =====
// Package of the voxel grid sampler: payload structs, status codes, register map.
// Depends on nothing; used by the top level.
`default_nettype none

package vgts_pkg;

  localparam int NUM_REGS = 6;
  localparam int CFG_AW   = 5;

  localparam logic [2:0] REG_BOX_MIN_X    = 3'd0;
  localparam logic [2:0] REG_BOX_MIN_Y    = 3'd1;
  localparam logic [2:0] REG_BOX_MIN_Z    = 3'd2;
  localparam logic [2:0] REG_INV_EXTENT_X = 3'd3;
  localparam logic [2:0] REG_INV_EXTENT_Y = 3'd4;
  localparam logic [2:0] REG_INV_EXTENT_Z = 3'd5;

  localparam logic [31:0] INV_EXTENT_RESET = 32'd16777216;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_INCOMPLETE = 2'd1;
  localparam logic [1:0] ST_BAD_DIMS   = 2'd2;

  typedef struct packed {
    logic               func;
    logic [7:0]         data_byte;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } in_item_t;

  typedef struct packed {
    logic [15:0] density;
    logic [1:0]  status;
  } out_item_t;

endpackage

`default_nettype wire

// ===== hw/rtl/vgts_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies; used for the voxel store of the sampler.
`default_nettype none

module vgts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/voxel_grid_trilinear_sampler.sv =====
// Top level of the trilinear voxel grid sampler: loader, mapper, read sequencer.
// Depends on vgts_pkg, vgts_ram and voxel_grid_trilinear_sampler_assert.svh.
//
//  port group  direction  transfer condition
//  in_*        sink       in_valid && !in_stall, item is in_data (in_item_t)
//  out_*       source     out_valid && !out_stall, item is out_data (out_item_t)
//  APB         slave      psel && penable && pwrite, registers at byte 4*i
//
// Load bytes are taken while the sequencer is idle; after the sixth header byte
// the block waits in S_WAIT1 and S_WAIT2 while the grid size product settles.
// A sample maps the three axes on one shared 32x32 multiplier, forms the corner
// addresses, makes eight reads of the single-ported voxel RAM, drains the blend
// pipeline and hands the result to the output register. No new item is taken
// until it is done; a sample rejected by status goes straight to S_DONE. The finished
// result waits in the output register, so a stalled output only holds the block
// when a second result is ready. rst_n is synchronous; the voxel RAM is not cleared.
`default_nettype none

module voxel_grid_trilinear_sampler #(
  parameter int MAX_DIM   = 64,
  parameter int FRAC_BITS = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire vgts_pkg::in_item_t           in_data,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output vgts_pkg::out_item_t               out_data,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [vgts_pkg::CFG_AW-1:0]  paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam int DEPTH = MAX_DIM * MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int DW    = $clog2(MAX_DIM + 1);
  localparam int IW    = $clog2(MAX_DIM);
  localparam int CBW   = 48 + DW;
  localparam logic [CBW-1:0] HALF_Q24 = CBW'(1) << 23;
  localparam logic [FRAC_BITS:0] ONE_F = (FRAC_BITS+1)'(1) << FRAC_BITS;
  localparam logic [15+FRAC_BITS+2:0] HALF_F = (FRAC_BITS+18)'(1) << (FRAC_BITS - 1);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_WAIT1 = 8'b0000_0010,
    S_WAIT2 = 8'b0000_0100,
    S_MAP   = 8'b0000_1000,
    S_ADDR  = 8'b0001_0000,
    S_READ  = 8'b0010_0000,
    S_DRAIN = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  // Rounded linear blend, a weighted by one minus w and b by w.
  function automatic logic [15:0] mix(input logic [15:0] a, input logic [15:0] b,
                                      input logic [FRAC_BITS-1:0] w);
    logic [FRAC_BITS+17:0] s;
    s = (FRAC_BITS+18)'(a) * (FRAC_BITS+18)'(ONE_F - {1'b0, w})
      + (FRAC_BITS+18)'(b) * (FRAC_BITS+18)'(w) + HALF_F;
    return s[FRAC_BITS+15:FRAC_BITS];
  endfunction

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [31:0] cfg_r [vgts_pkg::NUM_REGS];
  logic [2:0]  reg_idx;
  logic        cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[vgts_pkg::CFG_AW-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    prdata = 32'd0;
    if (reg_idx < 3'(vgts_pkg::NUM_REGS)) begin
      prdata = cfg_r[reg_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r[vgts_pkg::REG_BOX_MIN_X]    <= 32'd0;
      cfg_r[vgts_pkg::REG_BOX_MIN_Y]    <= 32'd0;
      cfg_r[vgts_pkg::REG_BOX_MIN_Z]    <= 32'd0;
      cfg_r[vgts_pkg::REG_INV_EXTENT_X] <= vgts_pkg::INV_EXTENT_RESET;
      cfg_r[vgts_pkg::REG_INV_EXTENT_Y] <= vgts_pkg::INV_EXTENT_RESET;
      cfg_r[vgts_pkg::REG_INV_EXTENT_Z] <= vgts_pkg::INV_EXTENT_RESET;
    end else if (cfg_wr && reg_idx < 3'(vgts_pkg::NUM_REGS)) begin
      cfg_r[reg_idx] <= pwdata;
    end
  end

  // Loader state: header bytes, dimensions, voxel count.
  logic [15:0]    dim_r [3];
  logic [2:0]     hdr_pos_r;
  logic [CW-1:0]  vox_cnt_r;
  logic           too_large_r;
  logic [2*DW-1:0] xy_r;
  logic [CW-1:0]  total_r;
  logic           in_xfer;
  logic           is_load;
  logic           hdr_done;
  logic [15:0]    dim_new;
  logic           store_we;
  logic [1:0]     chk_status;

  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign is_load  = (in_data.func == vgts_pkg::FUNC_LOAD);
  assign hdr_done = (hdr_pos_r == 3'd6);
  assign dim_new  = {dim_r[hdr_pos_r[2:1]][7:0], in_data.data_byte};
  assign store_we = in_xfer && is_load && hdr_done && !too_large_r
                    && (vox_cnt_r < total_r);

  // The total voxel count follows the dimensions through xy_r and then total_r; the sixth
  // header byte parks the block in S_WAIT1 and S_WAIT2 until it has settled.
  always_ff @(posedge clk) begin
    xy_r    <= dim_r[0][DW-1:0] * dim_r[1][DW-1:0];
    total_r <= CW'(xy_r) * CW'(dim_r[2][DW-1:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r[0]    <= 16'd0;
      dim_r[1]    <= 16'd0;
      dim_r[2]    <= 16'd0;
      hdr_pos_r   <= 3'd0;
      vox_cnt_r   <= '0;
      too_large_r <= 1'b0;
    end else if (in_xfer && is_load) begin
      if (!hdr_done) begin
        dim_r[hdr_pos_r[2:1]] <= dim_new;
        hdr_pos_r <= hdr_pos_r + 3'd1;
        if (hdr_pos_r == 3'd5) begin
          if (dim_r[0] == 16'd0 || dim_r[1] == 16'd0 || dim_new == 16'd0 ||
              dim_r[0] > 16'(MAX_DIM) || dim_r[1] > 16'(MAX_DIM) ||
              dim_new > 16'(MAX_DIM)) begin
            too_large_r <= 1'b1;
          end
        end
      end else if (store_we) begin
        vox_cnt_r <= vox_cnt_r + CW'(1);
      end
    end
  end

  always_comb begin
    if (!hdr_done) begin
      chk_status = vgts_pkg::ST_INCOMPLETE;
    end else if (too_large_r) begin
      chk_status = vgts_pkg::ST_BAD_DIMS;
    end else if (vox_cnt_r != total_r) begin
      chk_status = vgts_pkg::ST_INCOMPLETE;
    end else begin
      chk_status = vgts_pkg::ST_OK;
    end
  end

  // Axis mapper: a product phase and a result phase per axis, on one shared multiplier path.
  logic signed [31:0] pos_r [3];
  logic [1:0]         ax_r;
  logic               ph_r;
  logic [63:0]        prod_r;
  logic               gt_r;
  logic [IW-1:0]      lo_r [3];
  logic [IW-1:0]      hi_r [3];
  logic [FRAC_BITS-1:0] w_r [3];

  logic signed [32:0] diff;
  logic [DW-1:0]      size;
  logic [DW-1:0]      size_m1;
  logic [CBW-1:0]     c24;
  logic [CBW-1:0]     c_off;
  logic [CBW-25:0]    ip;
  logic [IW-1:0]      lo_nxt;
  logic [IW-1:0]      hi_nxt;
  logic [FRAC_BITS-1:0] w_nxt;

  assign diff    = 33'(pos_r[ax_r]) - 33'($signed(cfg_r[{1'b0, ax_r}]));
  assign size    = dim_r[ax_r][DW-1:0];
  assign size_m1 = size - DW'(1);
  assign c24     = CBW'(prod_r[63:16]) * CBW'(size);
  assign c_off   = c24 - HALF_Q24;
  assign ip      = c_off[CBW-1:24];

  always_comb begin
    lo_nxt = '0;
    w_nxt  = '0;
    if (gt_r && c24 >= HALF_Q24) begin
      if (ip >= (CBW-24)'(size_m1)) begin
        lo_nxt = size_m1[IW-1:0];
      end else begin
        lo_nxt = ip[IW-1:0];
        w_nxt  = c_off[23:24-FRAC_BITS];
      end
    end
    hi_nxt = ((DW'(lo_nxt) + DW'(1)) < size) ? lo_nxt + IW'(1) : lo_nxt;
  end

  always_ff @(posedge clk) begin
    if (state_r == S_MAP) begin
      if (!ph_r) begin
        prod_r <= 64'(diff[31:0]) * 64'(cfg_r[3'd3 + 3'(ax_r)]);
        gt_r   <= !diff[32] && (diff != 33'sd0);
      end else begin
        lo_r[ax_r] <= lo_nxt;
        hi_r[ax_r] <= hi_nxt;
        w_r[ax_r]  <= w_nxt;
      end
    end
  end

  // Corner address parts: z times the slab size, y times the row length.
  logic [AW-1:0] az0_r, az1_r, ay0_r, ay1_r;

  always_ff @(posedge clk) begin
    if (state_r == S_ADDR) begin
      az0_r <= AW'(xy_r) * AW'(lo_r[2]);
      az1_r <= AW'(xy_r) * AW'(hi_r[2]);
      ay0_r <= AW'(dim_r[0][DW-1:0]) * AW'(lo_r[1]);
      ay1_r <= AW'(dim_r[0][DW-1:0]) * AW'(hi_r[1]);
    end
  end

  // Voxel RAM: written by loads, read eight times per sample.
  logic [2:0]    rc_r;
  logic [AW-1:0] ram_addr;
  logic [AW-1:0] rd_addr;
  logic          ram_en;
  logic [7:0]    ram_rdata;

  assign rd_addr  = (rc_r[0] ? az1_r : az0_r) + (rc_r[1] ? ay1_r : ay0_r)
                  + AW'(rc_r[2] ? hi_r[0] : lo_r[0]);
  assign ram_addr = store_we ? vox_cnt_r[AW-1:0] : rd_addr;
  assign ram_en   = store_we || (state_r == S_READ);

  vgts_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .en    (ram_en),
    .we    (store_we),
    .addr  (ram_addr),
    .wdata (in_data.data_byte),
    .rdata (ram_rdata)
  );

  // Blend pipeline: z pairs, then y pairs, then the final x blend.
  logic        rd_v_r, zv_r, yv_r;
  logic [2:0]  rd_tag_r;
  logic [1:0]  ztag_r;
  logic        ytag_r;
  logic [15:0] va_r, zres_r, ya_r, yres_r, xa_r;
  logic [15:0] vox;
  logic        final_blend;

  assign vox         = {ram_rdata, ram_rdata};
  assign final_blend = yv_r && ytag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
      zv_r   <= 1'b0;
      yv_r   <= 1'b0;
    end else begin
      rd_v_r <= (state_r == S_READ);
      zv_r   <= rd_v_r && rd_tag_r[0];
      yv_r   <= zv_r && ztag_r[0];
    end
  end

  always_ff @(posedge clk) begin
    rd_tag_r <= rc_r;
    if (rd_v_r) begin
      if (!rd_tag_r[0]) begin
        va_r <= vox;
      end else begin
        zres_r <= mix(va_r, vox, w_r[2]);
        ztag_r <= rd_tag_r[2:1];
      end
    end
    if (zv_r) begin
      if (!ztag_r[0]) begin
        ya_r <= zres_r;
      end else begin
        yres_r <= mix(ya_r, zres_r, w_r[1]);
        ytag_r <= ztag_r[1];
      end
    end
    if (yv_r && !ytag_r) begin
      xa_r <= yres_r;
    end
  end

  // Result holding and output register.
  logic [15:0] res_dens_r;
  logic [1:0]  res_stat_r;
  logic        out_valid_r;
  vgts_pkg::out_item_t out_data_r;
  logic        out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_xfer) begin
      res_dens_r <= 16'd0;
      res_stat_r <= chk_status;
      pos_r[0]   <= in_data.pos_x;
      pos_r[1]   <= in_data.pos_y;
      pos_r[2]   <= in_data.pos_z;
    end else if (final_blend) begin
      res_dens_r <= mix(xa_r, yres_r, w_r[0]);
    end
    if (state_r == S_DONE && out_free) begin
      out_data_r.density <= res_dens_r;
      out_data_r.status  <= res_stat_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (is_load) begin
            if (hdr_pos_r == 3'd5) begin
              state_nxt = S_WAIT1;
            end
          end else if (chk_status == vgts_pkg::ST_OK) begin
            state_nxt = S_MAP;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_WAIT1: state_nxt = S_WAIT2;
      S_WAIT2: state_nxt = S_IDLE;
      S_MAP: begin
        if (ph_r && ax_r == 2'd2) begin
          state_nxt = S_ADDR;
        end
      end
      S_ADDR: state_nxt = S_READ;
      S_READ: begin
        if (rc_r == 3'd7) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (final_blend) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ax_r    <= 2'd0;
      ph_r    <= 1'b0;
      rc_r    <= 3'd0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_MAP) begin
        ph_r <= !ph_r;
        if (ph_r) begin
          ax_r <= (ax_r == 2'd2) ? 2'd0 : ax_r + 2'd1;
        end
      end
      if (state_r == S_READ) begin
        rc_r <= rc_r + 3'd1;
      end
    end
  end

`include "voxel_grid_trilinear_sampler_assert.svh"

  // Loads write the RAM only while the sequencer is idle.
  `VGTS_NEVER(a_write_only_idle, store_we && state_r != S_IDLE)
  // Once the header has settled, the store never holds more voxels than the grid.
  `VGTS_ASSERT(a_count_bounded, (hdr_done && !too_large_r && state_r == S_IDLE)
               |-> vox_cnt_r <= total_r)
  // A result that reports a problem carries zero density.
  `VGTS_ASSERT(a_bad_status_zero, out_valid_r |->
               (out_data_r.status == vgts_pkg::ST_OK || out_data_r.density == 16'd0))
  // The final blend of a sample only happens while draining the read pipeline.
  `VGTS_ASSERT(a_blend_in_drain, final_blend |-> state_r == S_DRAIN)

endmodule

`default_nettype wire
